// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker module.
// Depends on nothing; clock and reset are passed in by the user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock, disabled while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Concurrent implication, antecedent and consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  `ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons))

`endif

// ----- rtl/dq_pkg.sv -----
// Package for the double-ended queue: opcodes, status codes, response type.
// No dependencies.
`default_nettype none

package dq_pkg;

  localparam int OpW   = 4;
  localparam int DataW = 32;
  localparam int PosW  = 8;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_FRONT = 4'd0,
    OP_PUSH_BACK  = 4'd1,
    OP_POP_FRONT  = 4'd2,
    OP_POP_BACK   = 4'd3,
    OP_READ_AT    = 4'd4,
    OP_WRITE_AT   = 4'd5,
    OP_READ_FRONT = 4'd6,
    OP_READ_BACK  = 4'd7,
    OP_WRITE_FRONT = 4'd8,
    OP_WRITE_BACK = 4'd9
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    status_e status;
    logic    rd;
  } resp_t;

endpackage

`default_nettype wire

// ----- rtl/dq_ram.sv -----
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module dq_ram #(
  parameter int Width = 32,
  parameter int Depth = 256,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/dq_ctrl.sv -----
// Queue control: front pointer, occupancy, request decode and ring address.
// Depends on dq_pkg.
`default_nettype none

module dq_ctrl #(
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CntW = $clog2(DEPTH + 1)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      accept_i,
  input  wire logic [dq_pkg::OpW-1:0]    opcode_i,
  input  wire logic [dq_pkg::PosW-1:0]   position_i,
  output logic                           mem_en_o,
  output logic                           mem_we_o,
  output logic      [AW-1:0]             mem_addr_o,
  output dq_pkg::resp_t                  resp_o,
  output logic      [CntW-1:0]           count_o
);

  localparam int CmpW = (CntW > dq_pkg::PosW) ? CntW : dq_pkg::PosW;
  localparam logic [AW:0]     DepthA = (AW + 1)'(DEPTH);
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);
  localparam logic [AW-1:0]   LastA  = AW'(DEPTH - 1);

  logic [AW-1:0]   front_q, front_d, front_dec, offset, slot;
  logic [CntW-1:0] count_q, count_d, count_m1;
  logic [AW:0]     sum;
  logic [CmpW-1:0] pos_ext, count_ext;
  logic            full, empty, in_range;
  logic            wr, rd;
  dq_pkg::status_e status;
  dq_pkg::opcode_e op;

  assign op        = dq_pkg::opcode_e'(opcode_i);
  assign pos_ext   = CmpW'(position_i);
  assign count_ext = CmpW'(count_q);
  assign full      = (count_q == DepthC);
  assign empty     = (count_q == '0);
  assign in_range  = (pos_ext < count_ext);
  assign count_m1  = count_q - 1'b1;
  assign front_dec = (front_q == '0) ? LastA : front_q - 1'b1;

  // offset from the front, wrapped into the ring
  always_comb begin
    case (op)
      dq_pkg::OP_PUSH_BACK:                       offset = count_q[AW-1:0];
      dq_pkg::OP_READ_AT, dq_pkg::OP_WRITE_AT:    offset = pos_ext[AW-1:0];
      dq_pkg::OP_POP_FRONT:                       offset = AW'(1);
      dq_pkg::OP_READ_BACK, dq_pkg::OP_WRITE_BACK: offset = count_m1[AW-1:0];
      default:                                    offset = '0;
    endcase
  end

  assign sum  = {1'b0, front_q} + {1'b0, offset};
  assign slot = (sum >= DepthA) ? AW'(sum - DepthA) : sum[AW-1:0];

  always_comb begin
    status     = dq_pkg::ST_OK;
    wr         = 1'b0;
    rd         = 1'b0;
    mem_addr_o = slot;
    front_d    = front_q;
    count_d    = count_q;
    case (op)
      dq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          status = dq_pkg::ST_FULL;
        end else begin
          wr         = 1'b1;
          mem_addr_o = front_dec;
          front_d    = front_dec;
          count_d    = count_q + 1'b1;
        end
      end
      dq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status = dq_pkg::ST_FULL;
        end else begin
          wr      = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      dq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          status = dq_pkg::ST_EMPTY;
        end else begin
          front_d = slot;
          count_d = count_m1;
        end
      end
      dq_pkg::OP_POP_BACK: begin
        if (empty) begin
          status = dq_pkg::ST_EMPTY;
        end else begin
          count_d = count_m1;
        end
      end
      dq_pkg::OP_READ_AT, dq_pkg::OP_WRITE_AT: begin
        if (!in_range) begin
          status = dq_pkg::ST_RANGE;
        end else if (op == dq_pkg::OP_READ_AT) begin
          rd = 1'b1;
        end else begin
          wr = 1'b1;
        end
      end
      dq_pkg::OP_READ_FRONT, dq_pkg::OP_WRITE_FRONT: begin
        mem_addr_o = front_q;
        if (empty) begin
          status = dq_pkg::ST_EMPTY;
        end else if (op == dq_pkg::OP_READ_FRONT) begin
          rd = 1'b1;
        end else begin
          wr = 1'b1;
        end
      end
      dq_pkg::OP_READ_BACK, dq_pkg::OP_WRITE_BACK: begin
        if (empty) begin
          status = dq_pkg::ST_EMPTY;
        end else if (op == dq_pkg::OP_READ_BACK) begin
          rd = 1'b1;
        end else begin
          wr = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign mem_en_o = accept_i && (wr || rd);
  assign mem_we_o = wr;
  assign resp_o   = '{status: status, rd: rd};
  assign count_o  = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else if (accept_i) begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/double_ended_queue.sv -----
// Top level of the bounded double-ended queue of signed 32-bit words.
// Depends on dq_pkg, dq_ctrl and dq_ram.
//
// Usage:
//   Requests: drive opcode_i, data_in_i and position_i with start high; the
//   beat is taken at a rising edge where start is high and busy is low.
//   busy stays low, so a request may be issued in every cycle.
//   Results: exactly one per request, on status_o, data_out_o and
//   fill_count_o, marked by done_o for one cycle. done_o rises in the cycle
//   after the request beat, and the queue takes one request per cycle. The
//   single-port ring RAM sees at most one read or one write per request,
//   and its registered read output is the result word directly.
//   A read straight after a write to the same entry sees the new word, as
//   the write lands at the edge that ends the write's request cycle.
//   Reset clears the front pointer and the occupancy; the RAM is not
//   cleared, and only entries that hold words are ever read.
//   The receiver cannot stall: every result must be taken when done_o is high.
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CntW = $clog2(DEPTH + 1)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic        [dq_pkg::OpW-1:0]     opcode_i,
  input  wire logic signed [dq_pkg::DataW-1:0]   data_in_i,
  input  wire logic        [dq_pkg::PosW-1:0]    position_i,
  output logic                                   done_o,
  output logic             [1:0]                 status_o,
  output logic signed      [dq_pkg::DataW-1:0]   data_out_o,
  output logic             [CntW-1:0]            fill_count_o
);

  logic                      accept;
  logic                      mem_en, mem_we;
  logic [AW-1:0]             mem_addr;
  logic [dq_pkg::DataW-1:0]  rdata;
  dq_pkg::resp_t             resp, resp_q;
  logic                      done_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  dq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .opcode_i   (opcode_i),
    .position_i (position_i),
    .mem_en_o   (mem_en),
    .mem_we_o   (mem_we),
    .mem_addr_o (mem_addr),
    .resp_o     (resp),
    .count_o    (fill_count_o)
  );

  dq_ram #(
    .Width (dq_pkg::DataW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (data_in_i),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      resp_q <= resp;
    end
  end

  assign done_o     = done_q;
  assign status_o   = resp_q.status;
  assign data_out_o = (done_q && resp_q.rd) ? $signed(rdata) : '0;

endmodule

`default_nettype wire

// ----- rtl/dq_checker.sv -----
// Port-level checker for the double-ended queue, bound to the top level.
// Depends on dq_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module dq_checker #(
  parameter int DEPTH = 256,
  localparam int CntW = $clog2(DEPTH + 1)
) (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            start,
  input wire logic                            busy,
  input wire logic                            done_o,
  input wire logic        [1:0]               status_o,
  input wire logic signed [dq_pkg::DataW-1:0] data_out_o,
  input wire logic        [CntW-1:0]          fill_count_o
);

  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);

  // one result beat per request beat, in the cycle after it
  `ASSERT_CLK(a_one_result, clk_i, rst_ni, (start && !busy) |=> done_o)
  `ASSERT_CLK(a_no_spurious, clk_i, rst_ni, !(start && !busy) |=> !done_o)
  `ASSERT_IMPL(a_err_zero, clk_i, rst_ni, done_o && (status_o != dq_pkg::ST_OK), data_out_o == '0)
  `ASSERT_IMPL(a_full_count, clk_i, rst_ni, done_o && (status_o == dq_pkg::ST_FULL), fill_count_o == DepthC)
  `ASSERT_IMPL(a_count_held, clk_i, rst_ni, !done_o, $stable(fill_count_o))

endmodule

bind double_ended_queue dq_checker #(.DEPTH(DEPTH)) u_dq_checker (.*);

`default_nettype wire
